// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sliding window sender RTL.
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SWS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding window sender: implication check failed");

// Next-cycle implication
`define SWS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding window sender: next-cycle check failed");

`endif

// ===== rtl/swsend_pkg.sv =====
// Package for the sliding window sender: codes, constants, FSM and link types.
// No dependencies.
`timescale 1ns / 1ps
package swsend_pkg;

    localparam int WINDOW_MAX_DEF = 16;

    localparam logic [8:0]  FULL_PAYLOAD  = 9'd500;
    localparam logic [4:0]  WINDOW_RESET  = 5'd1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;

    typedef enum logic [1:0] {
        CMD_OFFER = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_SEND = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_RETX = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic exec_op;
        logic tick_start;
        logic scan_issue;
        logic emit_step;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t op;
        logic out_free;
        logic tick_active;
        logic scan_done;
        logic emit_done;
    } dp_status_t;

endpackage

// ===== rtl/swsend_ctrl.sv =====
// Sequencer for the sliding window sender.
// Depends on swsend_pkg; drives swsend_dp through ctrl_cmd_t.
`timescale 1ns / 1ps
module swsend_ctrl
    import swsend_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctrl.latch_in = 1'b1;
                    unique case (cmd_t'(s_tuser))
                        CMD_OFFER, CMD_ACK: state_next = ST_EXEC;
                        CMD_TICK:           state_next = ST_TICK;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    ctrl.exec_op = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                ctrl.tick_start = 1'b1;
                state_next      = status.tick_active ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                ctrl.scan_issue = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                ctrl.emit_step = 1'b1;
                if (status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/swsend_dp.sv =====
// Datapath for the sliding window sender: window state, timer memory, output register.
// Depends on swsend_pkg; sequenced by swsend_ctrl.
`timescale 1ns / 1ps
module swsend_dp
    import swsend_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  ctrl_cmd_t   ctrl,
    output dp_status_t  status,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int OW = $clog2(WINDOW_MAX + 1);
    localparam int AW = ((SW > OW) ? SW : OW) + 1;
    localparam int CW = (OW > 5) ? OW : 5;
    localparam int SLOT_INIT = 1 % WINDOW_MAX;

    // configuration
    logic [4:0]    window_reg;
    logic [15:0]   timeout_reg;

    // latched transaction
    cmd_t          op_reg;
    logic [8:0]    len_reg;
    logic [31:0]   ack_reg;

    // window state
    logic [31:0]   now_reg, now_next;
    logic [31:0]   acked_reg, acked_next;
    logic [31:0]   sent_reg, sent_next;
    logic [OW-1:0] outst_reg, outst_next;
    logic          eof_pend_reg, eof_pend_next;
    logic [31:0]   eof_seq_reg, eof_seq_next;
    logic          part_pend_reg, part_pend_next;
    logic [31:0]   part_seq_reg, part_seq_next;
    logic          done_reg, done_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;

    // tick scan and emit
    logic [OW-1:0]         scan_i_reg, scan_i_next;
    logic                  cmp_v_reg, cmp_v_next;
    logic [OW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [SW-1:0]         cmp_slot_reg, cmp_slot_next;
    logic [WINDOW_MAX-1:0] due_reg, due_next;
    logic [OW-1:0]         emit_j_reg, emit_j_next;

    // timer memory
    logic [31:0]   sent_time [WINDOW_MAX];
    logic [31:0]   rd_data_reg;
    logic [SW-1:0] rd_addr;
    logic          mem_we;
    logic [SW-1:0] mem_wa;

    // output register
    logic          m_tvalid_reg, m_tvalid_next;
    logic [39:0]   m_tdata_reg, m_tdata_next;
    logic [1:0]    m_tuser_reg, m_tuser_next;
    logic          m_tlast_reg, m_tlast_next;

    logic          out_free;
    logic          out_load;
    kind_t         out_kind;
    logic          out_acc;
    logic [31:0]   out_seq;
    logic          out_last;

    logic [CW-1:0] eff_win;
    logic          full_now;
    logic          len_full;
    logic          offer_ok;
    logic          ack_ok;
    logic [31:0]   latest;
    logic [31:0]   ack_count;
    logic [AW-1:0] head_sum;
    logic [AW-1:0] scan_sum;
    logic [31:0]   age;
    logic [WINDOW_MAX-1:0] due_rest;

    assign out_free = !m_tvalid_reg || m_tready;

    assign eff_win  = (CW'(window_reg) > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(window_reg);
    assign full_now = CW'(outst_reg) >= eff_win;
    assign len_full = len_reg >= FULL_PAYLOAD;

    assign offer_ok = !full_now && !done_reg && !eof_pend_reg
                      && !(part_pend_reg && !len_full) && (sent_reg != '1);

    assign ack_ok = (outst_reg != '0) && !done_reg
                    && ({1'b0, ack_reg} > ({1'b0, acked_reg} + 33'd1))
                    && ({1'b0, ack_reg} <= ({1'b0, sent_reg} + 33'd1));

    assign latest    = ack_reg - 32'd1;
    assign ack_count = latest - acked_reg;
    assign head_sum  = AW'(head_reg) + AW'(ack_count[OW-1:0]);
    assign scan_sum  = AW'(head_reg) + AW'(scan_i_reg);
    assign rd_addr   = (scan_sum >= AW'(WINDOW_MAX)) ? SW'(scan_sum - AW'(WINDOW_MAX))
                                                      : SW'(scan_sum);
    assign age       = now_reg - rd_data_reg;

    always_comb
    begin
        due_rest = due_reg;
        due_rest[emit_j_reg[SW-1:0]] = 1'b0;
    end

    always_comb
    begin
        now_next       = now_reg;
        acked_next     = acked_reg;
        sent_next      = sent_reg;
        outst_next     = outst_reg;
        eof_pend_next  = eof_pend_reg;
        eof_seq_next   = eof_seq_reg;
        part_pend_next = part_pend_reg;
        part_seq_next  = part_seq_reg;
        done_next      = done_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        scan_i_next    = scan_i_reg;
        cmp_v_next     = 1'b0;
        cmp_idx_next   = scan_i_reg;
        cmp_slot_next  = rd_addr;
        due_next       = due_reg;
        emit_j_next    = emit_j_reg;
        mem_we         = 1'b0;
        mem_wa         = tail_reg;
        out_load       = 1'b0;
        out_kind       = KIND_SEND;
        out_acc        = 1'b0;
        out_seq        = '0;
        out_last       = 1'b1;

        if (ctrl.exec_op)
        begin
            out_load = 1'b1;
            if (op_reg == CMD_OFFER)
            begin
                out_kind = KIND_SEND;
                out_acc  = offer_ok;
                if (offer_ok)
                begin
                    out_seq    = sent_reg + 32'd1;
                    sent_next  = sent_reg + 32'd1;
                    outst_next = outst_reg + OW'(1);
                    mem_we     = 1'b1;
                    mem_wa     = tail_reg;
                    tail_next  = (tail_reg == SW'(WINDOW_MAX - 1)) ? '0 : tail_reg + SW'(1);
                    if (len_reg == '0)
                    begin
                        eof_pend_next = 1'b1;
                        eof_seq_next  = sent_reg + 32'd1;
                    end
                    else if (!len_full)
                    begin
                        part_pend_next = 1'b1;
                        part_seq_next  = sent_reg + 32'd1;
                    end
                end
            end
            else
            begin
                out_kind = KIND_ACK;
                out_acc  = ack_ok;
                out_seq  = acked_reg;
                if (ack_ok)
                begin
                    out_seq    = latest;
                    acked_next = latest;
                    outst_next = (ack_count >= 32'(outst_reg)) ? '0
                                                                : outst_reg - OW'(ack_count);
                    head_next  = (head_sum >= AW'(WINDOW_MAX))
                                 ? SW'(head_sum - AW'(WINDOW_MAX)) : SW'(head_sum);
                    if (part_pend_reg && (part_seq_reg <= latest))
                    begin
                        part_pend_next = 1'b0;
                    end
                    if (eof_pend_reg && (eof_seq_reg <= latest))
                    begin
                        eof_pend_next = 1'b0;
                        done_next     = 1'b1;
                    end
                end
            end
        end

        if (ctrl.tick_start)
        begin
            now_next    = now_reg + 32'd1;
            scan_i_next = '0;
            due_next    = '0;
            emit_j_next = '0;
        end

        if (ctrl.scan_issue && (scan_i_reg < outst_reg))
        begin
            cmp_v_next  = 1'b1;
            scan_i_next = scan_i_reg + OW'(1);
        end

        if (cmp_v_reg && (age > 32'(timeout_reg)))
        begin
            mem_we = 1'b1;
            mem_wa = cmp_slot_reg;
            due_next[cmp_idx_reg[SW-1:0]] = 1'b1;
        end

        if (ctrl.emit_step && (due_reg != '0))
        begin
            if (!due_reg[emit_j_reg[SW-1:0]])
            begin
                emit_j_next = emit_j_reg + OW'(1);
            end
            else if (out_free)
            begin
                out_load    = 1'b1;
                out_kind    = KIND_RETX;
                out_acc     = 1'b1;
                out_seq     = acked_reg + 32'(emit_j_reg) + 32'd1;
                out_last    = (due_rest == '0);
                due_next    = due_rest;
                emit_j_next = emit_j_reg + OW'(1);
            end
        end
    end

    always_comb
    begin
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_load)
        begin
            m_tdata_next = {done_next, (CW'(outst_next) >= eff_win), 5'(outst_next),
                            out_seq, out_acc};
            m_tuser_next = out_kind;
            m_tlast_next = out_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sent_time[mem_wa] <= now_reg;
        end
        rd_data_reg <= sent_time[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch_in)
        begin
            op_reg  <= cmd_t'(s_tuser);
            len_reg <= s_tdata[8:0];
            ack_reg <= s_tdata[40:9];
        end
        cmp_idx_reg  <= cmp_idx_next;
        cmp_slot_reg <= cmp_slot_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            now_reg       <= '0;
            acked_reg     <= '0;
            sent_reg      <= '0;
            outst_reg     <= '0;
            eof_pend_reg  <= 1'b0;
            eof_seq_reg   <= '0;
            part_pend_reg <= 1'b0;
            part_seq_reg  <= '0;
            done_reg      <= 1'b0;
            head_reg      <= SW'(SLOT_INIT);
            tail_reg      <= SW'(SLOT_INIT);
            scan_i_reg    <= '0;
            cmp_v_reg     <= 1'b0;
            due_reg       <= '0;
            emit_j_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                priority if (cfg_index == REG_WINDOW)
                begin
                    window_reg <= cfg_data[4:0];
                end
                else if (cfg_index == REG_TIMEOUT)
                begin
                    timeout_reg <= cfg_data;
                end
            end
            now_reg       <= now_next;
            acked_reg     <= acked_next;
            sent_reg      <= sent_next;
            outst_reg     <= outst_next;
            eof_pend_reg  <= eof_pend_next;
            eof_seq_reg   <= eof_seq_next;
            part_pend_reg <= part_pend_next;
            part_seq_reg  <= part_seq_next;
            done_reg      <= done_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            scan_i_reg    <= scan_i_next;
            cmp_v_reg     <= cmp_v_next;
            due_reg       <= due_next;
            emit_j_reg    <= emit_j_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    assign status.op          = op_reg;
    assign status.out_free    = out_free;
    assign status.tick_active = (outst_reg != '0) && !done_reg;
    assign status.scan_done   = (scan_i_reg == outst_reg) && !cmp_v_reg;
    assign status.emit_done   = (due_reg == '0);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/sliding_window_sender_core.sv =====
// Offer and ack: accepted in ST_IDLE, result loaded in ST_EXEC once the output is free, then
// back to ST_IDLE for the next item. Tick: ST_TICK, then ST_SCAN reads the in-flight slots
// through the timer memory read port, then ST_EMIT steps the slots, one order per due slot; output stalls extend this.
// One item at a time; a held result does not block the next transaction's acceptance.
// rst_n asynchronous active low: window empty, window_size 1, timeout_ms 1000.
// Top level; depends on swsend_pkg, swsend_ctrl, swsend_dp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sliding_window_sender_core
    import swsend_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // payload_len[8:0], ack_number[40:9], zero fill
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // accepted, seq_number, in_flight, window_full, finished
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    swsend_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    swsend_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .ctrl      (ctrl),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    `SWS_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready && (s_tuser != CMD_RSVD), !s_tready)
    `SWS_ASSERT_IMP(a_exec_needs_slot, ctrl.exec_op, status.out_free)
    `SWS_ASSERT_IMP(a_one_phase, ctrl.scan_issue || ctrl.emit_step, !s_tready)

endmodule

// ===== tb/sv/sliding_window_sender_core_tb.sv =====
// Self-checking testbench for sliding_window_sender_core: offers, acks and ticks with
// random gaps and stalls, checked by a scoreboard with its own window predictor.
// Depends on swsend_pkg and the RTL of sliding_window_sender_core.
`timescale 1ns / 1ps

module sliding_window_sender_core_tb;
    import swsend_pkg::*;

    localparam int SLOTS = 16;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        kind_t       kind;
        bit          accepted;
        bit [31:0]   seq_number;
        bit [4:0]    in_flight;
        bit          window_full;
        bit          finished;
        bit          last;
    } window_result_t;

    class window_scoreboard;
        bit [4:0]  window_size;
        bit [15:0] timeout_ms;
        bit [31:0] now_ms;
        bit [31:0] last_acked;
        bit [31:0] last_sent;
        bit [4:0]  outstanding;
        bit        eof_pending;
        bit [31:0] eof_seq;
        bit        partial_pending;
        bit [31:0] partial_seq;
        bit        done_flag;
        bit [31:0] sent_time [SLOTS];
        window_result_t awaited [$];
        int        errors;
        int        n_items;
        int        n_results;
        int        n_retx;

        function new();
            window_size = WINDOW_RESET;
            timeout_ms  = TIMEOUT_RESET;
            now_ms = 0;
            last_acked = 0;
            last_sent = 0;
            outstanding = 0;
            eof_pending = 0;
            eof_seq = 0;
            partial_pending = 0;
            partial_seq = 0;
            done_flag = 0;
            errors = 0;
            n_items = 0;
            n_results = 0;
            n_retx = 0;
        endfunction

        function bit [4:0] eff_window();
            return (window_size > SLOTS) ? 5'(SLOTS) : window_size;
        endfunction

        function void write_reg(logic [1:0] idx, bit [15:0] val);
            if (idx == REG_WINDOW)
                window_size = val[4:0];
            else if (idx == REG_TIMEOUT)
                timeout_ms = val;
        endfunction

        function void push(kind_t k, bit acc, bit [31:0] seq);
            window_result_t r;
            r.kind = k;
            r.accepted = acc;
            r.seq_number = seq;
            r.in_flight = outstanding;
            r.window_full = (outstanding >= eff_window());
            r.finished = done_flag;
            r.last = 0;
            awaited.push_back(r);
        endfunction

        // one accepted input transaction
        function void note_input(cmd_t cmd, bit [8:0] len_in, bit [31:0] ack);
            bit [8:0]  len;
            bit        ok;
            bit [31:0] seq;
            bit [31:0] latest;
            bit [31:0] count;
            int        n_before;
            int        slot;
            n_before = awaited.size();
            len = (len_in > FULL_PAYLOAD) ? FULL_PAYLOAD : len_in;
            n_items++;
            case (cmd)
                CMD_OFFER:
                begin
                    ok = outstanding < eff_window() && !done_flag && !eof_pending
                         && !(partial_pending && len != FULL_PAYLOAD)
                         && last_sent != 32'hFFFF_FFFF;
                    seq = 0;
                    if (ok)
                    begin
                        seq = last_sent + 1;
                        last_sent = seq;
                        outstanding++;
                        sent_time[seq % SLOTS] = now_ms;
                        if (len == 0)
                        begin
                            eof_pending = 1;
                            eof_seq = seq;
                        end
                        else if (len < FULL_PAYLOAD)
                        begin
                            partial_pending = 1;
                            partial_seq = seq;
                        end
                    end
                    push(KIND_SEND, ok, seq);
                end
                CMD_ACK:
                begin
                    ok = outstanding != 0 && !done_flag
                         && {1'b0, ack} > {1'b0, last_acked} + 33'd1
                         && {1'b0, ack} <= {1'b0, last_sent} + 33'd1;
                    if (ok)
                    begin
                        latest = ack - 1;
                        count = latest - last_acked;
                        last_acked = latest;
                        outstanding = (count >= outstanding) ? 5'd0 : outstanding - count[4:0];
                        if (partial_pending && partial_seq <= latest)
                            partial_pending = 0;
                        if (eof_pending && eof_seq <= latest)
                        begin
                            eof_pending = 0;
                            done_flag = 1;
                        end
                    end
                    push(KIND_ACK, ok, last_acked);
                end
                CMD_TICK:
                begin
                    now_ms++;
                    if (outstanding != 0 && !done_flag)
                        for (int i = 0; i < outstanding && i < SLOTS; i++)
                        begin
                            seq = last_acked + 1 + i;
                            slot = seq % SLOTS;
                            if (now_ms - sent_time[slot] > {16'd0, timeout_ms})
                            begin
                                sent_time[slot] = now_ms;
                                push(KIND_RETX, 1'b1, seq);
                                n_retx++;
                            end
                        end
                end
                default: ;
            endcase
            if (awaited.size() > n_before)
                awaited[awaited.size() - 1].last = 1;
        endfunction

        task report(string what, logic [39:0] got, logic [39:0] want);
            errors++;
            $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        endtask

        task check_result(logic [1:0] kind, logic [39:0] data, logic last);
            window_result_t w;
            n_results++;
            if (awaited.size() == 0)
            begin
                report("unexpected result", {38'd0, kind}, 40'd0);
                return;
            end
            w = awaited.pop_front();
            if (kind !== w.kind)           report("kind", {38'd0, kind}, {38'd0, w.kind});
            if (data[0] !== w.accepted)    report("accepted", {39'd0, data[0]}, {39'd0, w.accepted});
            if (data[32:1] !== w.seq_number)
                report("seq_number", {8'd0, data[32:1]}, {8'd0, w.seq_number});
            if (data[37:33] !== w.in_flight)
                report("in_flight", {35'd0, data[37:33]}, {35'd0, w.in_flight});
            if (data[38] !== w.window_full)
                report("window_full", {39'd0, data[38]}, {39'd0, w.window_full});
            if (data[39] !== w.finished)   report("finished", {39'd0, data[39]}, {39'd0, w.finished});
            if (last !== w.last)           report("last", {39'd0, last}, {39'd0, w.last});
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // payload_len[8:0], ack_number[40:9], zero fill
    logic [1:0]  s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // accepted, seq_number, in_flight, window_full, finished
    logic [1:0]  m_tuser;   // kind
    logic        m_tlast;

    window_scoreboard sb;
    int unsigned cycle_no;
    int unsigned rx_hold;
    bit          hold_req;

    sliding_window_sender_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial clk = 0;
    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    function bit quiet();
        return cycle_no >= 3000 && cycle_no < 6000;
    endfunction

    // receiver: random stalls, repeated long hold-offs while requested
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (hold_req && rx_hold == 0)
        begin
            rx_hold <= 400;
            m_tready <= 0;
        end
        else if (rx_hold > 1)
        begin
            rx_hold <= rx_hold - 1;
            m_tready <= 0;
        end
        else
        begin
            if (rx_hold == 1)
                rx_hold <= 0;
            m_tready <= quiet() ? 1'b1 : ($urandom_range(0, 99) >= 23);
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);

    task send_item(cmd_t cmd, bit [8:0] len, bit [31:0] ack);
        while (!quiet() && $urandom_range(0, 99) < 23)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, ack, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(cmd, len, ack);
    endtask

    task wait_idle();
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, bit [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task random_item();
        int unsigned r;
        int unsigned span;
        bit [8:0]    len;
        bit [31:0]   ack;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)      len = FULL_PAYLOAD;
            else if (r < 85) len = 9'($urandom_range(501, 511));
            else             len = 9'($urandom_range(1, 499));
            send_item(CMD_OFFER, len, $urandom);
        end
        else if (r < 65)
        begin
            r = $urandom_range(0, 99);
            span = sb.last_sent - sb.last_acked;
            if (r < 80 && span > 0)
                ack = sb.last_acked + 2 + $urandom_range(0, span - 1);
            else if (r < 88)
                ack = sb.last_acked + 1;
            else if (r < 94)
                ack = sb.last_sent + 2;
            else
                ack = $urandom;
            send_item(CMD_ACK, 9'($urandom), ack);
        end
        else if (r < 97)
            send_item(CMD_TICK, 9'($urandom), $urandom);
        else
            send_item(CMD_RSVD, 9'($urandom), $urandom);
    endtask

    task run_phase(bit [15:0] win, bit [15:0] tmo, int n);
        wait_idle();
        write_reg(REG_WINDOW, win);
        write_reg(REG_TIMEOUT, tmo);
        repeat (n) random_item();
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = REG_WINDOW;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = CMD_OFFER;
        m_tready = 0;
        cycle_no = 0;
        rx_hold = 0;
        hold_req = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset values, zero window, clamped window, payload extremes
        send_item(CMD_OFFER, FULL_PAYLOAD, 32'd0);
        send_item(CMD_OFFER, FULL_PAYLOAD, 32'd0);
        send_item(CMD_ACK, 9'd0, 32'd2);
        wait_idle();
        write_reg(REG_WINDOW, 16'd0);
        write_reg(REG_TIMEOUT, 16'd0);
        send_item(CMD_OFFER, 9'd511, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 9'd0, 32'd0);
        wait_idle();
        write_reg(REG_WINDOW, 16'd31);
        send_item(CMD_OFFER, 9'd511, 32'd0);
        send_item(CMD_OFFER, 9'd1, 32'd0);
        send_item(CMD_OFFER, 9'd499, 32'd0);   // refused behind the partial packet
        send_item(CMD_OFFER, 9'd0, 32'd0);     // EOF refused behind the partial packet
        send_item(CMD_ACK, 9'd0, 32'd0);
        send_item(CMD_ACK, 9'd0, 32'hFFFF_FFFF);
        send_item(CMD_ACK, 9'd0, 32'd3);       // at last_acked + 2, acks one packet
        repeat (13) send_item(CMD_OFFER, FULL_PAYLOAD, 32'd0);
        send_item(CMD_OFFER, FULL_PAYLOAD, 32'd0);
        send_item(CMD_TICK, 9'd0, 32'd0);      // every slot due
        send_item(CMD_RSVD, 9'h1FF, 32'hFFFF_FFFF);
        send_item(CMD_ACK, 9'd0, 32'd4);       // covers the partial packet
        wait_idle();
        write_reg(REG_WINDOW, 16'd2);
        send_item(CMD_OFFER, FULL_PAYLOAD, 32'd0);
        send_item(CMD_TICK, 9'd0, 32'd0);

        hold_req <= 1;
        repeat (20) random_item();
        hold_req <= 0;
        run_phase(16'd4, 16'd2, 70);
        run_phase(16'd16, 16'd0, 70);
        run_phase(16'd1, 16'd65535, 50);
        run_phase(16'd3, 16'd5, 70);
        run_phase(16'd8, 16'd1, 60);

        // end of file: drain the window, then the EOF packet
        wait_idle();
        if (sb.last_sent != sb.last_acked)
            send_item(CMD_ACK, 9'd0, sb.last_sent + 1);
        send_item(CMD_OFFER, 9'd0, 32'd0);
        send_item(CMD_OFFER, FULL_PAYLOAD, 32'd0);
        send_item(CMD_TICK, 9'd0, 32'd0);
        send_item(CMD_ACK, 9'd0, sb.last_sent + 1);
        send_item(CMD_OFFER, FULL_PAYLOAD, 32'd0);
        send_item(CMD_ACK, 9'd0, sb.last_sent + 1);
        send_item(CMD_TICK, 9'd0, 32'd0);
        wait_idle();

        $display("covered %0d input transactions, %0d results, %0d retransmit orders",
                 sb.n_items, sb.n_results, sb.n_retx);
        $display("window sizes 0 to 31, timeouts 0 to 65535, EOF completion, long output hold");
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout after %0d cycles", cycle_no);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sliding_window_sender_core.f =====
+incdir+rtl
rtl/swsend_pkg.sv
rtl/swsend_ctrl.sv
rtl/swsend_dp.sv
rtl/sliding_window_sender_core.sv
tb/sv/sliding_window_sender_core_tb.sv
